// ----- hdl/frame_stream_deframer_top_defines.svh -----
// Assertion macros shared by the deframer checker.
`ifndef FRAME_STREAM_DEFRAMER_TOP_DEFINES_SVH
`define FRAME_STREAM_DEFRAMER_TOP_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define FSD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define FSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/fsd_pkg.sv -----
// Types and constants of the frame stream deframer.
`default_nettype none
package fsd_pkg;

    localparam int HEADER_BYTES = 12;
    localparam int STORE_BYTES  = HEADER_BYTES - 1;
    localparam int HIDX_W       = 4;

    localparam logic [31:0] FRAME_MAGIC   = 32'h454c_5437;
    localparam logic [7:0]  FRAME_VERSION = 8'd1;

    // Byte classes of a result beat
    localparam logic [1:0] CLS_HEADER  = 2'd0;
    localparam logic [1:0] CLS_NAME    = 2'd1;
    localparam logic [1:0] CLS_PAYLOAD = 2'd2;
    localparam logic [1:0] CLS_DISCARD = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_MAGIC   = 3'd1;
    localparam logic [2:0] ERR_VERSION = 3'd2;
    localparam logic [2:0] ERR_TYPE    = 3'd3;
    localparam logic [2:0] ERR_NAME    = 3'd4;
    localparam logic [2:0] ERR_PAYLOAD = 3'd5;

    // Register indexes
    localparam logic [1:0] REG_MAX_NAME    = 2'd0;
    localparam logic [1:0] REG_MAX_PAYLOAD = 2'd1;
    localparam logic [1:0] REG_TYPE_LOW    = 2'd2;
    localparam logic [1:0] REG_TYPE_HIGH   = 2'd3;

    typedef logic [STORE_BYTES-1:0][7:0] t_hdr_store;

    typedef struct packed {
        logic [15:0] max_name_len;
        logic [31:0] max_payload_len;
        logic [7:0]  type_lowest;
        logic [7:0]  type_highest;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  code;
        logic [7:0]  kind;
        logic [15:0] name_len;
        logic [31:0] payload_len;
    } t_hdr_chk;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [1:0]  byte_class;
        logic [7:0]  kind_of_frame;
        logic [15:0] name_len;
        logic [31:0] payload_len;
        logic        header_accepted;
        logic        frame_end;
        logic [2:0]  error_code;
    } t_result;

endpackage
`default_nettype wire

// ----- hdl/fsd_if.sv -----
// Stream interfaces of the deframer: byte input and result output.
`default_nettype none
interface fsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface fsd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [1:0]  byte_class;
    logic [7:0]  kind_of_frame;
    logic [15:0] name_len;
    logic [31:0] payload_len;
    logic        header_accepted;
    logic        frame_end;
    logic [2:0]  error_code;

    modport source (output valid, output out_byte, output byte_class, output kind_of_frame,
                    output name_len, output payload_len, output header_accepted,
                    output frame_end, output error_code, input ready);
    modport sink   (input valid, input out_byte, input byte_class, input kind_of_frame,
                    input name_len, input payload_len, input header_accepted,
                    input frame_end, input error_code, output ready);
endinterface
`default_nettype wire

// ----- hdl/fsd_hdr_check.sv -----
// Header field decode and validity checks on the last header byte.
`default_nettype none
module fsd_hdr_check (
    input  fsd_pkg::t_hdr_store i_store,
    input  logic [7:0]          i_last,
    input  fsd_pkg::t_cfg       i_cfg,
    output fsd_pkg::t_hdr_chk   o_chk
);
    import fsd_pkg::*;

    logic [31:0] magic;
    logic [7:0]  version;
    logic [2:0]  code;

    // Assemble big-endian fields
    assign magic             = {i_store[0], i_store[1], i_store[2], i_store[3]};
    assign version           = i_store[4];
    assign o_chk.kind        = i_store[5];
    assign o_chk.name_len    = {i_store[6], i_store[7]};
    assign o_chk.payload_len = {i_store[8], i_store[9], i_store[10], i_last};
    assign o_chk.code        = code;

    // Pick the first failing check
    always_comb begin
        if (magic != FRAME_MAGIC) begin
            code = ERR_MAGIC;
        end else if (version != FRAME_VERSION) begin
            code = ERR_VERSION;
        end else if (o_chk.kind < i_cfg.type_lowest || o_chk.kind > i_cfg.type_highest) begin
            code = ERR_TYPE;
        end else if (o_chk.name_len > i_cfg.max_name_len) begin
            code = ERR_NAME;
        end else if (o_chk.payload_len > i_cfg.max_payload_len) begin
            code = ERR_PAYLOAD;
        end else begin
            code = ERR_NONE;
        end
    end
endmodule
`default_nettype wire

// ----- hdl/frame_stream_deframer_top.sv -----
// Top level of the frame stream deframer: byte sequencing, config registers, result register.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+--------------------------------------------------
//  i_in     | in  | valid/ready   | in_byte[7:0]
//  o_out    | out | valid/ready   | out_byte, byte_class, kind_of_frame, name_len,
//           |     |               | payload_len, header_accepted, frame_end, error_code
//  APB      | in  | psel/penable  | paddr[3:0], pwdata[31:0], prdata[31:0]
//
// One byte is accepted per cycle while the input is not stalled; its result is
// registered in the output register in the cycle after acceptance. The byte
// counter, header store and length counters update in the cycle of acceptance,
// so throughput is one beat per cycle. Input is stalled only while the output
// register holds a beat not yet taken. Reset (synchronous, active low) returns
// to the header phase, clears the sticky error and loads the register defaults.
`default_nettype none
module frame_stream_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fsd_in_if.sink      i_in,
    fsd_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fsd_pkg::*;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_NAME    = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_ERROR   = 2'd3;

    localparam logic [HIDX_W-1:0] HIDX_LAST = HIDX_W'(STORE_BYTES);

    t_cfg              r_cfg;
    logic [1:0]        r_phase,     n_phase;
    logic [HIDX_W-1:0] r_hidx,      n_hidx;
    t_hdr_store        r_store;
    logic [15:0]       r_name_left, n_name_left;
    logic [31:0]       r_pay_left,  n_pay_left;
    logic [7:0]        r_kind,      n_kind;
    logic [15:0]       r_name_len,  n_name_len;
    logic [31:0]       r_pay_len,   n_pay_len;
    logic [2:0]        r_err,       n_err;
    t_result           r_out,       n_out;
    logic              r_out_vld;
    logic              in_fire;
    logic              cfg_wr;
    logic              show;
    t_hdr_chk          chk;

    fsd_hdr_check u_hdr_check (
        .i_store (r_store),
        .i_last  (i_in.in_byte),
        .i_cfg   (r_cfg),
        .o_chk   (chk)
    );

    // Accept while the result register is free or being drained
    assign i_in.ready = !r_out_vld || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_name_len    <= 16'd255;
            r_cfg.max_payload_len <= 32'd65536;
            r_cfg.type_lowest     <= 8'd1;
            r_cfg.type_highest    <= 8'd8;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_MAX_NAME:    r_cfg.max_name_len    <= pwdata[15:0];
                REG_MAX_PAYLOAD: r_cfg.max_payload_len <= pwdata;
                REG_TYPE_LOW:    r_cfg.type_lowest     <= pwdata[7:0];
                REG_TYPE_HIGH:   r_cfg.type_highest    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MAX_NAME:    prdata = {16'd0, r_cfg.max_name_len};
            REG_MAX_PAYLOAD: prdata = r_cfg.max_payload_len;
            REG_TYPE_LOW:    prdata = {24'd0, r_cfg.type_lowest};
            REG_TYPE_HIGH:   prdata = {24'd0, r_cfg.type_highest};
            default:         prdata = 32'd0;
        endcase
    end

    // Sequence one byte through the frame phases
    always_comb begin
        n_phase     = r_phase;
        n_hidx      = r_hidx;
        n_name_left = r_name_left;
        n_pay_left  = r_pay_left;
        n_kind      = r_kind;
        n_name_len  = r_name_len;
        n_pay_len   = r_pay_len;
        n_err       = r_err;
        show        = 1'b0;
        n_out       = '0;
        n_out.out_byte = i_in.in_byte;
        case (r_phase)
            PH_HEADER: begin
                n_out.byte_class = CLS_HEADER;
                if (r_hidx != HIDX_LAST) begin
                    n_hidx = r_hidx + HIDX_W'(1);
                end else begin
                    n_hidx = '0;
                    if (chk.code != ERR_NONE) begin
                        n_err   = chk.code;
                        n_phase = PH_ERROR;
                    end else begin
                        n_out.header_accepted = 1'b1;
                        show        = 1'b1;
                        n_kind      = chk.kind;
                        n_name_len  = chk.name_len;
                        n_pay_len   = chk.payload_len;
                        n_name_left = chk.name_len;
                        n_pay_left  = chk.payload_len;
                        if (chk.name_len != 16'd0) begin
                            n_phase = PH_NAME;
                        end else if (chk.payload_len != 32'd0) begin
                            n_phase = PH_PAYLOAD;
                        end else begin
                            n_out.frame_end = 1'b1;
                        end
                    end
                end
            end
            PH_NAME: begin
                n_out.byte_class = CLS_NAME;
                show        = 1'b1;
                n_name_left = r_name_left - 16'd1;
                if (n_name_left == 16'd0) begin
                    if (r_pay_left != 32'd0) begin
                        n_phase = PH_PAYLOAD;
                    end else begin
                        n_phase = PH_HEADER;
                        n_out.frame_end = 1'b1;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_out.byte_class = CLS_PAYLOAD;
                show       = 1'b1;
                n_pay_left = r_pay_left - 32'd1;
                if (n_pay_left == 32'd0) begin
                    n_phase = PH_HEADER;
                    n_out.frame_end = 1'b1;
                end
            end
            default: begin
                n_out.byte_class = CLS_DISCARD;
            end
        endcase
        if (show) begin
            n_out.kind_of_frame = n_kind;
            n_out.name_len      = n_name_len;
            n_out.payload_len   = n_pay_len;
        end
        n_out.error_code = n_err;
    end

    // Advance control state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hidx      <= '0;
            r_name_left <= '0;
            r_pay_left  <= '0;
            r_kind      <= '0;
            r_name_len  <= '0;
            r_pay_len   <= '0;
            r_err       <= ERR_NONE;
        end else if (in_fire) begin
            r_phase     <= n_phase;
            r_hidx      <= n_hidx;
            r_name_left <= n_name_left;
            r_pay_left  <= n_pay_left;
            r_kind      <= n_kind;
            r_name_len  <= n_name_len;
            r_pay_len   <= n_pay_len;
            r_err       <= n_err;
        end
    end

    // Capture header bytes ahead of the check
    always_ff @(posedge i_clk) begin
        if (in_fire && r_phase == PH_HEADER && r_hidx != HIDX_LAST) begin
            r_store[r_hidx] <= i_in.in_byte;
        end
    end

    // Result register: load on accept, drop on take
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (in_fire) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid           = r_out_vld;
    assign o_out.out_byte        = r_out.out_byte;
    assign o_out.byte_class      = r_out.byte_class;
    assign o_out.kind_of_frame   = r_out.kind_of_frame;
    assign o_out.name_len        = r_out.name_len;
    assign o_out.payload_len     = r_out.payload_len;
    assign o_out.header_accepted = r_out.header_accepted;
    assign o_out.frame_end       = r_out.frame_end;
    assign o_out.error_code      = r_out.error_code;
endmodule
`default_nettype wire

// ----- hdl/fsd_checker.sv -----
// Port-level checks of the deframer result stream, bound to the top level.
`default_nettype none
`include "frame_stream_deframer_top_defines.svh"
module fsd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        i_ready,
    input wire logic [7:0]  i_out_byte,
    input wire logic [1:0]  i_byte_class,
    input wire logic        i_header_accepted,
    input wire logic        i_frame_end,
    input wire logic [2:0]  i_error_code
);
    import fsd_pkg::*;

    // Hold a stalled beat
    `FSD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_out_byte) && $stable(i_byte_class) && $stable(i_error_code), "stalled result beat changed")

    // An accepted header carries no error and is a header byte
    `FSD_ASSERT_IMPL(a_accept_clean, i_clk, i_rst_n, i_valid && i_header_accepted, i_error_code == ERR_NONE && i_byte_class == CLS_HEADER, "header accepted with error or wrong class")

    // Discarded bytes only follow a latched error
    `FSD_ASSERT_IMPL(a_discard_err, i_clk, i_rst_n, i_valid && i_byte_class == CLS_DISCARD, i_error_code != ERR_NONE, "discarded byte without error")

    // Frame end never appears once an error is latched
    `FSD_ASSERT_IMPL(a_end_clean, i_clk, i_rst_n, i_valid && i_frame_end, i_error_code == ERR_NONE && i_byte_class != CLS_DISCARD, "frame end after error")
endmodule

bind frame_stream_deframer_top fsd_checker u_fsd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (o_out.valid),
    .i_ready           (o_out.ready),
    .i_out_byte        (o_out.out_byte),
    .i_byte_class      (o_out.byte_class),
    .i_header_accepted (o_out.header_accepted),
    .i_frame_end       (o_out.frame_end),
    .i_error_code      (o_out.error_code)
);
`default_nettype wire

// ----- dv/frame_stream_deframer_top_test.sv -----
// Self-checking testbench of the frame stream deframer: byte stream in, checked result beats out.
`timescale 1ns / 100ps
module frame_stream_deframer_top_test;
    import fsd_pkg::*;

    localparam int RX_HOLD_CYCLES = 300;
    localparam int RANDOM_BYTES   = 700;
    localparam int PRINT_CAP      = 40;

    typedef enum logic [1:0] {PH_HEAD, PH_NAME, PH_BODY, PH_HALT} t_parse_phase;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    fsd_in_if  in_bus ();
    fsd_out_if out_bus ();

    frame_stream_deframer_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Parser state mirrored by the byte decoder
    t_parse_phase parse_phase;
    int unsigned  hdr_count;
    logic [7:0]   hdr_bytes [STORE_BYTES];
    logic [15:0]  name_rem;
    logic [31:0]  body_rem;
    logic [7:0]   cur_kind;
    logic [15:0]  cur_name_len;
    logic [31:0]  cur_payload_len;
    logic [2:0]   err_latched;
    t_cfg         shadow_cfg;

    t_result expected_beats [$];

    int mismatch_count = 0;
    int beats_checked  = 0;
    int headers_ok     = 0;
    int frames_closed  = 0;
    int bytes_offered  = 0;
    int cfg_writes     = 0;
    int rx_hold_left   = 0;
    int rx_stall_left  = 0;
    bit traffic_gaps   = 1'b1;

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #40_000_000;
        $display("frame_stream_deframer_top_test NOT OK");
        $finish;
    end

    // Gap length: mostly none, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Advance the parser by one byte and return the beat it must produce
    function automatic t_result decode_byte(input logic [7:0] value);
        t_result     r;
        logic        show;
        logic [31:0] magic;
        logic [31:0] pl;
        logic [15:0] nl;
        logic [7:0]  ty;
        logic [2:0]  code;
        r = '0;
        r.out_byte = value;
        show = 1'b0;
        case (parse_phase)
            PH_HEAD: begin
                r.byte_class = CLS_HEADER;
                if (hdr_count < STORE_BYTES) begin
                    hdr_bytes[hdr_count] = value;
                    hdr_count++;
                end else begin
                    magic = {hdr_bytes[0], hdr_bytes[1], hdr_bytes[2], hdr_bytes[3]};
                    ty    = hdr_bytes[5];
                    nl    = {hdr_bytes[6], hdr_bytes[7]};
                    pl    = {hdr_bytes[8], hdr_bytes[9], hdr_bytes[10], value};
                    // first failing check wins
                    if (magic != FRAME_MAGIC) code = ERR_MAGIC;
                    else if (hdr_bytes[4] != FRAME_VERSION) code = ERR_VERSION;
                    else if (ty < shadow_cfg.type_lowest || ty > shadow_cfg.type_highest)
                        code = ERR_TYPE;
                    else if (nl > shadow_cfg.max_name_len) code = ERR_NAME;
                    else if (pl > shadow_cfg.max_payload_len) code = ERR_PAYLOAD;
                    else code = ERR_NONE;
                    hdr_count = 0;
                    if (code != ERR_NONE) begin
                        err_latched = code;
                        parse_phase = PH_HALT;
                    end else begin
                        r.header_accepted = 1'b1;
                        show            = 1'b1;
                        cur_kind        = ty;
                        cur_name_len    = nl;
                        cur_payload_len = pl;
                        name_rem        = nl;
                        body_rem        = pl;
                        if (nl != 0) parse_phase = PH_NAME;
                        else if (pl != 0) parse_phase = PH_BODY;
                        else r.frame_end = 1'b1;
                    end
                end
            end
            PH_NAME: begin
                r.byte_class = CLS_NAME;
                show = 1'b1;
                name_rem = name_rem - 16'd1;
                if (name_rem == 0) begin
                    if (body_rem != 0) begin
                        parse_phase = PH_BODY;
                    end else begin
                        parse_phase = PH_HEAD;
                        r.frame_end = 1'b1;
                    end
                end
            end
            PH_BODY: begin
                r.byte_class = CLS_PAYLOAD;
                show = 1'b1;
                body_rem = body_rem - 32'd1;
                if (body_rem == 0) begin
                    parse_phase = PH_HEAD;
                    r.frame_end = 1'b1;
                end
            end
            default: begin
                r.byte_class = CLS_DISCARD;
            end
        endcase
        if (show) begin
            r.kind_of_frame = cur_kind;
            r.name_len      = cur_name_len;
            r.payload_len   = cur_payload_len;
        end
        r.error_code = err_latched;
        return r;
    endfunction

    task automatic flag_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    function automatic string field_msg(input string field, input logic [31:0] got_v,
                                        input logic [31:0] want_v);
        return $sformatf("beat %0d %s: got 0x%0h, want 0x%0h", beats_checked, field,
                         got_v, want_v);
    endfunction

    // Check every beat the block hands over against the oldest predicted one
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            got = '{out_byte: out_bus.out_byte, byte_class: out_bus.byte_class,
                    kind_of_frame: out_bus.kind_of_frame, name_len: out_bus.name_len,
                    payload_len: out_bus.payload_len, header_accepted: out_bus.header_accepted,
                    frame_end: out_bus.frame_end, error_code: out_bus.error_code};
            if (expected_beats.size() == 0) begin
                flag_failure($sformatf("beat %0d arrived with no byte pending (out_byte 0x%0h)",
                                       beats_checked, got.out_byte));
            end else begin
                want = expected_beats.pop_front();
                if (got.out_byte !== want.out_byte)
                    flag_failure(field_msg("out_byte", got.out_byte, want.out_byte));
                if (got.byte_class !== want.byte_class)
                    flag_failure(field_msg("byte_class", got.byte_class, want.byte_class));
                if (got.kind_of_frame !== want.kind_of_frame)
                    flag_failure(field_msg("kind_of_frame", got.kind_of_frame,
                                           want.kind_of_frame));
                if (got.name_len !== want.name_len)
                    flag_failure(field_msg("name_len", got.name_len, want.name_len));
                if (got.payload_len !== want.payload_len)
                    flag_failure(field_msg("payload_len", got.payload_len, want.payload_len));
                if (got.header_accepted !== want.header_accepted)
                    flag_failure(field_msg("header_accepted", got.header_accepted,
                                           want.header_accepted));
                if (got.frame_end !== want.frame_end)
                    flag_failure(field_msg("frame_end", got.frame_end, want.frame_end));
                if (got.error_code !== want.error_code)
                    flag_failure(field_msg("error_code", got.error_code, want.error_code));
            end
            beats_checked++;
            if (got.header_accepted === 1'b1) headers_ok++;
            if (got.frame_end === 1'b1) frames_closed++;
        end
    end

    // Drive ready: long hold-off first, then random stalls while gaps are on, else always ready
    initial begin : result_side
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                out_bus.ready = 1'b0;
                rx_hold_left--;
            end else if (!traffic_gaps) begin
                out_bus.ready = 1'b1;
            end else if (rx_stall_left > 0) begin
                out_bus.ready = 1'b0;
                rx_stall_left--;
            end else begin
                out_bus.ready = 1'b1;
                rx_stall_left = pick_gap();
            end
        end
    end

    // Offer one byte, hold it until taken, then predict its beat
    task automatic send_byte(input logic [7:0] value);
        int unsigned gap;
        gap = traffic_gaps ? pick_gap() : 0;
        if (gap != 0) begin
            in_bus.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_bus.valid   = 1'b1;
        in_bus.in_byte = value;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        expected_beats.push_back(decode_byte(value));
        bytes_offered++;
        @(negedge i_clk);
        in_bus.valid = 1'b0;
    endtask

    // Header in network order, then body_len random bytes
    task automatic send_frame(input logic [31:0] magic, input logic [7:0] ver,
                              input logic [7:0] ty, input logic [15:0] nl,
                              input logic [31:0] pl, input int unsigned body_len);
        logic [95:0] hdr;
        hdr = {magic, ver, ty, nl, pl};
        for (int i = 0; i < HEADER_BYTES; i++) send_byte(hdr[95 - 8 * i -: 8]);
        repeat (body_len) send_byte(8'($urandom_range(0, 255)));
    endtask

    // Well-formed frame within the current limits and the given caps
    task automatic send_good_frame(input int unsigned name_cap, input int unsigned pay_cap);
        logic [7:0]  ty;
        int unsigned nl_top;
        int unsigned pl_top;
        int unsigned nl;
        int unsigned pl;
        nl_top = (shadow_cfg.max_name_len < name_cap) ? shadow_cfg.max_name_len : name_cap;
        pl_top = (shadow_cfg.max_payload_len < pay_cap) ? shadow_cfg.max_payload_len : pay_cap;
        ty = 8'($urandom_range(shadow_cfg.type_lowest, shadow_cfg.type_highest));
        nl = $urandom_range(0, nl_top);
        pl = $urandom_range(0, pl_top);
        send_frame(FRAME_MAGIC, FRAME_VERSION, ty, 16'(nl), pl, nl + pl);
    endtask

    // Pause the byte side until every predicted beat is out
    task automatic drain_results();
        while (expected_beats.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] rd_ignored;
        apb_xfer(1'b1, idx, value, rd_ignored);
        cfg_writes++;
        case (idx)
            REG_MAX_NAME:    shadow_cfg.max_name_len    = value[15:0];
            REG_MAX_PAYLOAD: shadow_cfg.max_payload_len = value;
            REG_TYPE_LOW:    shadow_cfg.type_lowest     = value[7:0];
            REG_TYPE_HIGH:   shadow_cfg.type_highest    = value[7:0];
            default: ;
        endcase
    endtask

    // Write all four limits once idle; junk above the register width must be dropped
    task automatic load_limits(input logic [15:0] name_lim, input logic [31:0] pay_lim,
                               input logic [7:0] lo, input logic [7:0] hi);
        drain_results();
        set_register(REG_MAX_NAME, {16'($urandom), name_lim});
        set_register(REG_MAX_PAYLOAD, pay_lim);
        set_register(REG_TYPE_LOW, {24'($urandom), lo});
        set_register(REG_TYPE_HIGH, {24'($urandom), hi});
    endtask

    task automatic verify_registers();
        logic [31:0] rd;
        logic [31:0] want;
        logic [1:0]  idx;
        for (int i = 0; i < 4; i++) begin
            idx = 2'(i);
            case (idx)
                REG_MAX_NAME:    want = {16'd0, shadow_cfg.max_name_len};
                REG_MAX_PAYLOAD: want = shadow_cfg.max_payload_len;
                REG_TYPE_LOW:    want = {24'd0, shadow_cfg.type_lowest};
                default:         want = {24'd0, shadow_cfg.type_highest};
            endcase
            apb_xfer(1'b0, idx, 32'd0, rd);
            if (rd !== want)
                flag_failure($sformatf("register %0d reads 0x%0h, want 0x%0h", i, rd, want));
        end
    endtask

    task automatic check_register_defaults();
        verify_registers();
    endtask

    task automatic run_directed_frames();
        // empty name and payload: frame end lands on the accepting header byte
        send_frame(FRAME_MAGIC, FRAME_VERSION, shadow_cfg.type_lowest, 16'd0, 32'd0, 0);
        // empty name: the payload byte follows the header directly
        send_frame(FRAME_MAGIC, FRAME_VERSION, shadow_cfg.type_highest, 16'd0, 32'd1, 0);
        send_byte(8'hFF);
        drain_results();
    endtask

    task automatic sweep_limit_extremes();
        load_limits(16'd0, 32'd0, 8'd0, 8'd0);
        verify_registers();
        repeat (3) send_good_frame(8, 24);
        load_limits(16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
        verify_registers();
        repeat (3) send_good_frame(8, 24);
        load_limits(16'd0, 32'hFFFF_FFFF, 8'd0, 8'hFF);
        verify_registers();
        repeat (3) send_good_frame(8, 24);
        load_limits(16'hFFFF, 32'd0, 8'd7, 8'd200);
        verify_registers();
        repeat (3) send_good_frame(12, 24);
        drain_results();
    endtask

    task automatic stall_result_side();
        load_limits(16'd64, 32'd1024, 8'd1, 8'd8);
        // hold the result side while bytes keep coming, so the input backs up
        traffic_gaps = 1'b0;
        rx_hold_left = RX_HOLD_CYCLES;
        send_frame(FRAME_MAGIC, FRAME_VERSION, 8'd3, 16'd6, 32'd40, 46);
        drain_results();
        traffic_gaps = 1'b1;
        repeat (4) send_good_frame(8, 24);
        drain_results();
    endtask

    task automatic run_random_traffic();
        int unsigned start_count;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [15:0] name_lim;
        logic [31:0] pay_lim;
        int unsigned roll;
        // one longer frame with a payload past 8 bits, no gaps
        load_limits(16'hFFFF, 32'hFFFF_FFFF, 8'd0, 8'hFF);
        traffic_gaps = 1'b0;
        send_frame(FRAME_MAGIC, FRAME_VERSION, 8'($urandom_range(0, 255)), 16'd48,
                   32'd260, 48 + 260);
        drain_results();
        traffic_gaps = 1'b1;
        start_count = bytes_offered;
        while (bytes_offered - start_count < RANDOM_BYTES) begin
            if ($urandom_range(0, 7) == 0) begin
                lo       = 8'($urandom_range(0, 255));
                hi       = 8'($urandom_range(lo, 255));
                name_lim = $urandom_range(0, 1) ? 16'($urandom_range(0, 16))
                                                : 16'($urandom_range(0, 65535));
                pay_lim  = $urandom_range(0, 1) ? 32'($urandom_range(0, 64)) : $urandom;
                load_limits(name_lim, pay_lim, lo, hi);
            end
            traffic_gaps = ($urandom_range(0, 4) != 0);
            roll = $urandom_range(0, 99);
            send_good_frame((roll < 90) ? 8 : 80, (roll < 85) ? 24 : 300);
        end
        drain_results();
        traffic_gaps = 1'b1;
    endtask

    // The error is sticky until reset, so this comes last
    task automatic end_with_header_error();
        logic [2:0]  fail_code;
        bit          flip_range;
        logic [15:0] name_lim;
        logic [31:0] pay_lim;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [31:0] magic;
        logic [7:0]  ver;
        logic [7:0]  ty;
        logic [15:0] nl;
        logic [31:0] pl;
        fail_code  = ERR_MAGIC + 3'($urandom_range(0, 4));
        flip_range = (fail_code <= ERR_TYPE) && ($urandom_range(0, 1) == 1);
        name_lim   = 16'($urandom_range(0, 16'hFFFE));
        pay_lim    = $urandom_range(0, 32'hFFFF_FFFE);
        if (flip_range) begin
            lo = 8'($urandom_range(1, 255));
            hi = 8'($urandom_range(0, lo - 1));
        end else begin
            lo = 8'($urandom_range(1, 200));
            hi = lo + 8'($urandom_range(0, 54));
        end
        load_limits(name_lim, pay_lim, lo, hi);

        // checks ahead of the failing one pass, the failing one fails, later ones are random
        magic = (fail_code == ERR_MAGIC) ? (FRAME_MAGIC ^ ($urandom | 32'h1)) : FRAME_MAGIC;
        if (fail_code == ERR_VERSION) ver = FRAME_VERSION ^ 8'($urandom_range(1, 255));
        else if (fail_code < ERR_VERSION) ver = 8'($urandom_range(0, 255));
        else ver = FRAME_VERSION;
        if (fail_code < ERR_TYPE || (fail_code == ERR_TYPE && flip_range))
            ty = 8'($urandom_range(0, 255));
        else if (fail_code == ERR_TYPE)
            ty = $urandom_range(0, 1) ? 8'($urandom_range(0, lo - 1))
                                      : 8'($urandom_range(hi + 1, 255));
        else ty = 8'($urandom_range(lo, hi));
        if (fail_code == ERR_NAME) nl = 16'($urandom_range(name_lim + 1, 16'hFFFF));
        else if (fail_code < ERR_NAME) nl = 16'($urandom);
        else nl = 16'($urandom_range(0, name_lim));
        if (fail_code == ERR_PAYLOAD) pl = $urandom_range(pay_lim + 1, 32'hFFFF_FFFF);
        else pl = $urandom;
        send_frame(magic, ver, ty, nl, pl, 0);

        // everything after is discarded, a well-formed empty frame included
        send_frame(FRAME_MAGIC, FRAME_VERSION, lo, 16'd0, 32'd0, 0);
        repeat (30) send_byte(8'($urandom_range(0, 255)));
        drain_results();
    endtask

    initial begin : stimulus
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_bus.valid   = 1'b0;
        in_bus.in_byte = 8'd0;
        shadow_cfg = '{max_name_len: 16'd255, max_payload_len: 32'd65536,
                       type_lowest: 8'd1, type_highest: 8'd8};
        parse_phase     = PH_HEAD;
        hdr_count       = 0;
        name_rem        = '0;
        body_rem        = '0;
        cur_kind        = '0;
        cur_name_len    = '0;
        cur_payload_len = '0;
        err_latched     = ERR_NONE;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        check_register_defaults();
        run_directed_frames();
        sweep_limit_extremes();
        stall_result_side();
        run_random_traffic();
        end_with_header_error();

        repeat (4) @(negedge i_clk);
        $display("Checked %0d beats from %0d bytes: %0d headers accepted, %0d frames ended.",
                 beats_checked, bytes_offered, headers_ok, frames_closed);
        $display("Used %0d register writes; the stream stopped on header error code %0d.",
                 cfg_writes, err_latched);
        if (mismatch_count == 0) begin
            $display("frame_stream_deframer_top_test OK");
        end else begin
            $display("frame_stream_deframer_top_test NOT OK");
        end
        $finish;
    end

endmodule
